// ===== rtl/view_frustum_cull_test_unit_assert.svh =====
// Assertion macros for the view frustum cull test unit.
// Used by the port-level checker; needs clk and rst_n in scope.
`ifndef VIEW_FRUSTUM_CULL_TEST_UNIT_ASSERT_SVH
`define VIEW_FRUSTUM_CULL_TEST_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define VFC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define VFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/vfc_pkg.sv =====
// Shared types, constants and plane-word unpack helpers for the
// view frustum cull test unit. No dependencies.
`timescale 1ns / 1ps

package vfc_pkg;

  localparam int NUM_PLANES = 6;   // planes tested, 1..6; NUM_LANES caps it at PLANE_REGS
  localparam int PLANE_REGS = 6;   // plane registers present
  localparam int NUM_LANES  = (NUM_PLANES < PLANE_REGS) ? NUM_PLANES : PLANE_REGS;

  localparam int CFG_IDX_W  = 3;
  localparam int PLANE_W    = 64;
  localparam int COORD_W    = 24;
  localparam int EXT_W      = 23;
  localparam int COEF_W     = 14;
  localparam int OFFS_W     = 22;
  localparam int FRAC_ALIGN = 12;  // d and radius scaled to 20 fractional bits

  localparam int PROD_W     = COEF_W + COORD_W;  // signed a*x
  localparam int BOXP_W     = COEF_W + EXT_W;    // unsigned |a|*ex
  localparam int BOX_W      = BOXP_W + 2;        // sum of three
  localparam int DIST_W     = 42;

  typedef enum logic [1:0] {
    ACT_POINT  = 2'd0,
    ACT_SPHERE = 2'd1,
    ACT_BOX    = 2'd2
  } act_t;

  typedef logic [PLANE_W-1:0] plane_t;

  typedef struct packed {
    logic [1:0]                action;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [EXT_W-1:0]          ex;
    logic [EXT_W-1:0]          ey;
    logic [EXT_W-1:0]          ez;
  } obj_t;

  // what the final compare stage needs besides the distances
  typedef struct packed {
    logic [1:0]       action;
    logic [EXT_W-1:0] ex;
  } ctl_t;

  function automatic logic signed [COEF_W-1:0] plane_a(input plane_t p);
    return p[13:0];
  endfunction

  function automatic logic signed [COEF_W-1:0] plane_b(input plane_t p);
    return p[27:14];
  endfunction

  function automatic logic signed [COEF_W-1:0] plane_c(input plane_t p);
    return p[41:28];
  endfunction

  function automatic logic signed [OFFS_W-1:0] plane_d(input plane_t p);
    return p[63:42];
  endfunction

  // magnitude of a coefficient; -8192 maps to 8192 as unsigned
  function automatic logic [COEF_W-1:0] coef_abs(input logic signed [COEF_W-1:0] v);
    return v[COEF_W-1] ? COEF_W'(-v) : COEF_W'(v);
  endfunction

endpackage

// ===== rtl/vfc_plane_regs.sv =====
// Six 64-bit plane registers behind the configuration write channel.
// Depends on vfc_pkg.
`timescale 1ns / 1ps

module vfc_plane_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  input  logic [vfc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vfc_pkg::PLANE_W-1:0]    cfg_data,
  output logic                           cfg_ready,
  output vfc_pkg::plane_t                planes [vfc_pkg::PLANE_REGS]
);

  assign cfg_ready = 1'b1;

  for (genvar i = 0; i < vfc_pkg::PLANE_REGS; i++) begin : g_reg
    vfc_pkg::plane_t plane_r;
    vfc_pkg::plane_t plane_nxt;

    // indexes past the last register match nothing and are dropped
    always_comb begin
      plane_nxt = plane_r;
      if (cfg_valid && cfg_index == vfc_pkg::CFG_IDX_W'(i)) begin
        plane_nxt = cfg_data;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        plane_r <= '0;
      end else begin
        plane_r <= plane_nxt;
      end
    end

    assign planes[i] = plane_r;
  end

endmodule

// ===== rtl/vfc_plane_lane.sv =====
// One plane's distance pipeline: products, sums, then the cull compare.
// Depends on vfc_pkg.
`timescale 1ns / 1ps

module vfc_plane_lane (
  input  logic            clk,
  input  vfc_pkg::plane_t plane,
  input  vfc_pkg::obj_t   obj_s0,
  input  vfc_pkg::ctl_t   ctl_s2,
  output logic            cull
);

  localparam int PW = vfc_pkg::PROD_W;
  localparam int QW = vfc_pkg::BOXP_W;
  localparam int BW = vfc_pkg::BOX_W;
  localparam int DW = vfc_pkg::DIST_W;

  logic signed [vfc_pkg::COEF_W-1:0] a, b, c;
  logic signed [vfc_pkg::OFFS_W-1:0] d;

  logic signed [PW-1:0] pax_nxt, pby_nxt, pcz_nxt;
  logic signed [PW-1:0] pax_r, pby_r, pcz_r;
  logic [QW-1:0]        qax_nxt, qby_nxt, qcz_nxt;
  logic [QW-1:0]        qax_r, qby_r, qcz_r;

  logic signed [DW-1:0] dist_nxt, dist_r;
  logic [BW-1:0]        box_nxt, box_r;

  logic signed [DW-1:0] d_ext;
  logic signed [DW-1:0] margin;
  logic signed [DW-1:0] total;

  assign a = vfc_pkg::plane_a(plane);
  assign b = vfc_pkg::plane_b(plane);
  assign c = vfc_pkg::plane_c(plane);
  assign d = vfc_pkg::plane_d(plane);

  // stage 1: one multiplier per term
  always_comb begin
    pax_nxt = a * obj_s0.x;
    pby_nxt = b * obj_s0.y;
    pcz_nxt = c * obj_s0.z;
    qax_nxt = vfc_pkg::coef_abs(a) * obj_s0.ex;
    qby_nxt = vfc_pkg::coef_abs(b) * obj_s0.ey;
    qcz_nxt = vfc_pkg::coef_abs(c) * obj_s0.ez;
  end

  // stage 2: plane distance at 20 fractional bits, and farthest-corner reach
  always_comb begin
    d_ext    = DW'(d);
    dist_nxt = DW'(pax_r) + DW'(pby_r) + DW'(pcz_r) + (d_ext <<< vfc_pkg::FRAC_ALIGN);
    box_nxt  = BW'(qax_r) + BW'(qby_r) + BW'(qcz_r);
  end

  always_ff @(posedge clk) begin
    pax_r  <= pax_nxt;
    pby_r  <= pby_nxt;
    pcz_r  <= pcz_nxt;
    qax_r  <= qax_nxt;
    qby_r  <= qby_nxt;
    qcz_r  <= qcz_nxt;
    dist_r <= dist_nxt;
    box_r  <= box_nxt;
  end

  // stage 3: culled when distance plus allowance is negative
  always_comb begin
    unique case (ctl_s2.action)
      vfc_pkg::ACT_POINT:  margin = '0;
      vfc_pkg::ACT_SPHERE: margin = DW'(ctl_s2.ex) <<< vfc_pkg::FRAC_ALIGN;
      default:             margin = DW'(box_r);  // box, and the unused code
    endcase
    total = dist_r + margin;
    cull  = total[DW-1];
  end

endmodule

// ===== rtl/view_frustum_cull_test_unit.sv =====
// Top level of the view frustum cull test unit.
// Depends on vfc_pkg, vfc_plane_regs and vfc_plane_lane.
`timescale 1ns / 1ps

// Tests a point, sphere or axis-aligned box against six frustum planes.
// Planes: written through cfg_valid/cfg_ready with cfg_index 0..5 (near,
//   far, left, right, top, bottom) and 64-bit cfg_data; other indexes are
//   dropped. cfg_ready is always high. Write only while no test is in flight.
// Tests: a transaction is taken at each clock edge with start high; busy
//   stays low, so one test can enter every cycle.
// Results: out_valid pulses for one cycle with out_visible once the test has
//   passed the input register (loaded at the accepting edge), then the
//   product, sum and result registers. Results come back in order, one per
//   test. Sustained rate is one test per cycle; every plane has its own
//   lane of six multipliers, so nothing is shared between tests in flight.
// Reset (rst_n low, synchronous): planes clear to zero, which never cull,
//   and all in-flight tests are dropped.
// The receiver cannot stall; out_valid is never held off.
module view_frustum_cull_test_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_action,
  input  logic signed [23:0]            in_center_x,
  input  logic signed [23:0]            in_center_y,
  input  logic signed [23:0]            in_center_z,
  input  logic [22:0]                   in_extent_x,
  input  logic [22:0]                   in_extent_y,
  input  logic [22:0]                   in_extent_z,
  output logic                          out_valid,
  output logic                          out_visible,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [vfc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vfc_pkg::PLANE_W-1:0]   cfg_data
);

  vfc_pkg::plane_t planes [vfc_pkg::PLANE_REGS];

  vfc_pkg::obj_t obj_r;
  vfc_pkg::obj_t obj_nxt;
  vfc_pkg::ctl_t ctl_s1_r, ctl_s2_r;
  logic          v0_r, v1_r, v2_r, out_valid_r;
  logic          visible_r, visible_nxt;
  logic [vfc_pkg::NUM_LANES-1:0] cull;

  assign busy = 1'b0;

  vfc_plane_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .planes    (planes)
  );

  always_comb begin
    obj_nxt.action = in_action;
    obj_nxt.x      = in_center_x;
    obj_nxt.y      = in_center_y;
    obj_nxt.z      = in_center_z;
    obj_nxt.ex     = in_extent_x;
    obj_nxt.ey     = in_extent_y;
    obj_nxt.ez     = in_extent_z;
  end

  for (genvar i = 0; i < vfc_pkg::NUM_LANES; i++) begin : g_lane
    vfc_plane_lane u_lane (
      .clk    (clk),
      .plane  (planes[i]),
      .obj_s0 (obj_r),
      .ctl_s2 (ctl_s2_r),
      .cull   (cull[i])
    );
  end

  assign visible_nxt = ~|cull;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v0_r        <= start && !busy;
      v1_r        <= v0_r;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  // payload pipeline, no reset
  always_ff @(posedge clk) begin
    obj_r     <= obj_nxt;
    ctl_s1_r  <= '{action: obj_r.action, ex: obj_r.ex};
    ctl_s2_r  <= ctl_s1_r;
    visible_r <= visible_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_visible = visible_r;

endmodule

// ===== rtl/vfc_checker.sv =====
// Port-level checker for the view frustum cull test unit, bound to the top.
// Depends on view_frustum_cull_test_unit_assert.svh and vfc_pkg.
`timescale 1ns / 1ps
`include "view_frustum_cull_test_unit_assert.svh"

module vfc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_valid,
  input logic                          cfg_valid,
  input logic                          cfg_ready,
  input logic [vfc_pkg::CFG_IDX_W-1:0] cfg_index
);

  logic took;
  assign took = start && !busy;

  `VFC_ASSERT_NOW(a_busy_low, 1'b1, !busy, "busy raised")
  `VFC_ASSERT_NOW(a_result_has_cause, out_valid, $past(took, 4), "result without a transaction")
  `VFC_ASSERT_NEXT(a_result_follows, took, ##3 out_valid, "transaction lost its result")
  `VFC_ASSERT_NOW(a_cfg_always_ready, cfg_valid, cfg_ready && (cfg_index == cfg_index), "cfg stalled")

endmodule

bind view_frustum_cull_test_unit vfc_checker u_vfc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready),
  .cfg_index (cfg_index)
);

// ===== test/cull_checker.sv =====
// Checker for the view frustum cull test unit: tracks plane writes, predicts
// the visible flag of each accepted test and compares it with the result port.
// Depends on vfc_pkg.
`timescale 1ns / 1ps

module cull_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic [1:0]                    in_action,
  input  logic signed [23:0]            in_center_x,
  input  logic signed [23:0]            in_center_y,
  input  logic signed [23:0]            in_center_z,
  input  logic [22:0]                   in_extent_x,
  input  logic [22:0]                   in_extent_y,
  input  logic [22:0]                   in_extent_z,
  input  logic                          out_valid,
  input  logic                          out_visible,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [vfc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vfc_pkg::PLANE_W-1:0]   cfg_data,
  output int                            fail_count,
  output int                            outstanding,
  output int                            tests_checked,
  output int                            tests_visible
);

  logic [vfc_pkg::PLANE_W-1:0] plane_q [vfc_pkg::PLANE_REGS];
  logic                        visible_q [$];

  function automatic longint coef_mag(input logic signed [13:0] v);
    return (v < 0) ? -longint'(v) : longint'(v);
  endfunction

  // Exact plane distances at 20 fractional bits; any plane may cull.
  function automatic logic survives_planes(
    input logic [1:0]         kind,
    input logic signed [23:0] px,
    input logic signed [23:0] py,
    input logic signed [23:0] pz,
    input logic [22:0]        hx,
    input logic [22:0]        hy,
    input logic [22:0]        hz
  );
    logic signed [13:0] ca, cb, cc;
    logic signed [21:0] cd;
    longint             plane_dist, reach;
    logic               keep;
    keep = 1'b1;
    for (int p = 0; p < vfc_pkg::PLANE_REGS && p < vfc_pkg::NUM_PLANES; p++) begin
      ca = plane_q[p][13:0];
      cb = plane_q[p][27:14];
      cc = plane_q[p][41:28];
      cd = plane_q[p][63:42];
      plane_dist = longint'(ca) * longint'(px) + longint'(cb) * longint'(py) +
                   longint'(cc) * longint'(pz) + longint'(cd) * 4096;
      case (kind)
        vfc_pkg::ACT_POINT: begin
          if (plane_dist < 0) keep = 1'b0;
        end
        vfc_pkg::ACT_SPHERE: begin
          if (plane_dist < -(longint'(hx) * 4096)) keep = 1'b0;
        end
        default: begin
          // unused code falls into the box test; farthest corner decides
          reach = plane_dist + coef_mag(ca) * longint'(hx) + coef_mag(cb) * longint'(hy) +
                  coef_mag(cc) * longint'(hz);
          if (reach < 0) keep = 1'b0;
        end
      endcase
    end
    return keep;
  endfunction

  always @(posedge clk) begin
    logic want;
    if (!rst_n) begin
      foreach (plane_q[i]) plane_q[i] = '0;
      visible_q.delete();
      fail_count    <= 0;
      outstanding   <= 0;
      tests_checked <= 0;
      tests_visible <= 0;
    end else begin
      if (cfg_valid && cfg_ready && cfg_index < vfc_pkg::PLANE_REGS)
        plane_q[cfg_index] = cfg_data;
      if (out_valid) begin
        if (visible_q.size() == 0) begin
          $display("%0t: unexpected result transaction: expected none, actual visible=%0b",
                   $time, out_visible);
          fail_count <= fail_count + 1;
        end else begin
          want = visible_q.pop_front();
          if (want !== out_visible) begin
            $display("%0t: visible mismatch: expected %0b, actual %0b",
                     $time, want, out_visible);
            fail_count <= fail_count + 1;
          end
          tests_checked <= tests_checked + 1;
          tests_visible <= tests_visible + int'(out_visible === 1'b1);
        end
      end
      if (start && !busy)
        visible_q.push_back(survives_planes(in_action, in_center_x, in_center_y,
                                            in_center_z, in_extent_x, in_extent_y,
                                            in_extent_z));
      outstanding <= visible_q.size();
    end
  end

endmodule

// ===== test/tb.sv =====
// Testbench top for the view frustum cull test unit: clock, reset, plane
// setup, directed and random test transactions, verdict.
// Depends on vfc_pkg, view_frustum_cull_test_unit and cull_checker.
`timescale 1ns / 1ps

module tb;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int         EDGE       = 100 * 256;  // cube frustum half size, Q8

  logic                          clk;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  logic [1:0]                    in_action;
  logic signed [23:0]            in_center_x, in_center_y, in_center_z;
  logic [22:0]                   in_extent_x, in_extent_y, in_extent_z;
  logic                          out_valid;
  logic                          out_visible;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [vfc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [vfc_pkg::PLANE_W-1:0]   cfg_data;

  int                            fail_count, outstanding, tests_checked, tests_visible;
  logic [vfc_pkg::PLANE_W-1:0]   frustum [vfc_pkg::PLANE_REGS];
  bit                            steady;
  int                            settings_used;
  int                            span;

  view_frustum_cull_test_unit i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_center_x(in_center_x), .in_center_y(in_center_y),
    .in_center_z(in_center_z), .in_extent_x(in_extent_x), .in_extent_y(in_extent_y),
    .in_extent_z(in_extent_z), .out_valid(out_valid), .out_visible(out_visible),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  cull_checker i_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_center_x(in_center_x), .in_center_y(in_center_y),
    .in_center_z(in_center_z), .in_extent_x(in_extent_x), .in_extent_y(in_extent_y),
    .in_extent_z(in_extent_z), .out_valid(out_valid), .out_visible(out_visible),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .fail_count(fail_count), .outstanding(outstanding),
    .tests_checked(tests_checked), .tests_visible(tests_visible)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic [vfc_pkg::PLANE_W-1:0] pack_plane(input int a, input int b,
                                                              input int c, input int d);
    return {d[21:0], c[13:0], b[13:0], a[13:0]};
  endfunction

  function automatic vfc_pkg::obj_t mk(input logic [1:0] act, input int x, input int y,
                                       input int z, input int ex, input int ey,
                                       input int ez);
    vfc_pkg::obj_t t;
    t.action = act;
    t.x  = x[23:0];
    t.y  = y[23:0];
    t.z  = z[23:0];
    t.ex = ex[22:0];
    t.ey = ey[22:0];
    t.ez = ez[22:0];
    return t;
  endfunction

  function automatic int rand_coord(input int lim);
    int v;
    if ($urandom_range(99) < 15) v = $urandom;
    else v = int'($urandom_range(2 * lim)) - lim;
    return v;
  endfunction

  function automatic int rand_extent(input int lim);
    int r;
    r = $urandom_range(99);
    if (r < 10) return 0;
    if (r < 30) return $urandom;
    return $urandom_range(lim / 2);
  endfunction

  function automatic vfc_pkg::obj_t rand_test(input int lim);
    logic [1:0] act;
    int         r;
    r = $urandom_range(99);
    if (r < 30)      act = vfc_pkg::ACT_POINT;
    else if (r < 60) act = vfc_pkg::ACT_SPHERE;
    else if (r < 95) act = vfc_pkg::ACT_BOX;
    else             act = ACT_UNUSED;
    return mk(act, rand_coord(lim), rand_coord(lim), rand_coord(lim),
              rand_extent(lim), rand_extent(lim), rand_extent(lim));
  endfunction

  function automatic int rand_coef();
    return int'($urandom_range(16383)) - 8192;
  endfunction

  // called right after the rising clock; returns once the test is accepted
  task automatic send_test(input vfc_pkg::obj_t t);
    while (!steady && $urandom_range(99) < 19) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start       <= 1'b1;
    in_action   <= t.action;
    in_center_x <= t.x;
    in_center_y <= t.y;
    in_center_z <= t.z;
    in_extent_x <= t.ex;
    in_extent_y <= t.ey;
    in_extent_z <= t.ez;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // writes all plane registers, then optionally the unmapped indexes
  task automatic load_frustum(input bit junk);
    for (int i = 0; i < vfc_pkg::PLANE_REGS + 2; i++) begin
      if (i < vfc_pkg::PLANE_REGS || junk) begin
        cfg_valid <= 1'b1;
        cfg_index <= i[vfc_pkg::CFG_IDX_W-1:0];
        cfg_data  <= (i < vfc_pkg::PLANE_REGS) ? frustum[i] : {$urandom, $urandom};
        do @(posedge clk); while (!cfg_ready);
      end
    end
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic plan_phase(input int ph, output int lim);
    int h, pick;
    lim = 1 << 22;
    case (ph % 5)
      0: begin
        h = $urandom_range(256, (1 << 21) - 1);
        frustum[0] = pack_plane(0, 0, 4096, h);
        frustum[1] = pack_plane(0, 0, -4096, h);
        frustum[2] = pack_plane(4096, 0, 0, h);
        frustum[3] = pack_plane(-4096, 0, 0, h);
        frustum[4] = pack_plane(0, -4096, 0, h);
        frustum[5] = pack_plane(0, 4096, 0, h);
        lim = 2 * h;
      end
      1: begin
        foreach (frustum[i])
          frustum[i] = pack_plane(rand_coef(), rand_coef(), rand_coef(),
                                  $urandom_range((1 << 21) - 1));
        lim = $urandom_range(256, 1 << 20);
      end
      2: begin
        foreach (frustum[i]) frustum[i] = {$urandom, $urandom};
      end
      3: begin
        foreach (frustum[i]) begin
          pick = $urandom_range(4);
          case (pick)
            0: frustum[i] = '1;
            1: frustum[i] = pack_plane(-8192, -8192, -8192, -(1 << 21));
            2: frustum[i] = pack_plane(8191, 8191, 8191, (1 << 21) - 1);
            3: frustum[i] = '0;
            default: frustum[i] = pack_plane(-8192, 8191, -8192, (1 << 21) - 1);
          endcase
        end
      end
      default: begin
        foreach (frustum[i])
          frustum[i] = $urandom_range(1) ?
                       pack_plane(rand_coef(), rand_coef(), rand_coef(),
                                  $urandom_range((1 << 21) - 1)) : '0;
        lim = $urandom_range(256, 1 << 20);
      end
    endcase
  endtask

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    rst_n       = 1'b0;
    start       = 1'b0;
    in_action   = vfc_pkg::ACT_POINT;
    in_center_x = '0;
    in_center_y = '0;
    in_center_z = '0;
    in_extent_x = '0;
    in_extent_y = '0;
    in_extent_z = '0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    steady      = 1'b0;
    settings_used = 1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // zero planes after reset never cull
    send_test(mk(vfc_pkg::ACT_POINT, -8388608, -8388608, -8388608, 0, 0, 0));
    send_test(mk(vfc_pkg::ACT_SPHERE, 8388607, 8388607, 8388607, 8388607, 0, 0));
    send_test(mk(vfc_pkg::ACT_BOX, 8388607, -8388608, 0, 8388607, 8388607, 8388607));
    send_test(mk(ACT_UNUSED, 0, 0, 0, 0, 0, 0));
    drain();

    // cube frustum of half size 100, junk writes to unmapped indexes must not land
    frustum[0] = pack_plane(0, 0, 4096, EDGE);
    frustum[1] = pack_plane(0, 0, -4096, EDGE);
    frustum[2] = pack_plane(4096, 0, 0, EDGE);
    frustum[3] = pack_plane(-4096, 0, 0, EDGE);
    frustum[4] = pack_plane(0, -4096, 0, EDGE);
    frustum[5] = pack_plane(0, 4096, 0, EDGE);
    load_frustum(1'b1);
    send_test(mk(vfc_pkg::ACT_POINT, 0, 0, 0, 0, 0, 0));
    send_test(mk(vfc_pkg::ACT_POINT, EDGE, -EDGE, EDGE, 0, 0, 0));      // on the boundary
    send_test(mk(vfc_pkg::ACT_POINT, EDGE + 1, 0, 0, 0, 0, 0));
    send_test(mk(vfc_pkg::ACT_POINT, 0, 0, -EDGE - 1, 8388607, 8388607, 8388607));
    send_test(mk(vfc_pkg::ACT_POINT, 8388607, 8388607, 8388607, 0, 0, 0));
    send_test(mk(vfc_pkg::ACT_SPHERE, EDGE + 256, 0, 0, 256, 0, 0));    // touching
    send_test(mk(vfc_pkg::ACT_SPHERE, EDGE + 257, 0, 0, 256, 8388607, 8388607));
    send_test(mk(vfc_pkg::ACT_SPHERE, 0, -EDGE - 256, 0, 256, 0, 0));
    send_test(mk(vfc_pkg::ACT_SPHERE, -8388608, 0, 0, 8388607, 0, 0));
    send_test(mk(vfc_pkg::ACT_BOX, EDGE + 12800, 0, 0, 12800, 1, 1));
    send_test(mk(vfc_pkg::ACT_BOX, EDGE + 12800, 0, 0, 12799, 1, 1));
    send_test(mk(vfc_pkg::ACT_BOX, 0, 0, EDGE + 12801, 0, 0, 12800));
    send_test(mk(vfc_pkg::ACT_BOX, EDGE + 500, EDGE + 500, EDGE + 500, 500, 500, 500));
    send_test(mk(vfc_pkg::ACT_BOX, EDGE + 501, EDGE + 501, EDGE + 501, 500, 500, 500));
    send_test(mk(vfc_pkg::ACT_BOX, -8388608, 8388607, -8388608, 8388607, 8388607,
                 8388607));
    send_test(mk(ACT_UNUSED, EDGE + 12800, 0, 0, 12800, 0, 0));
    send_test(mk(ACT_UNUSED, EDGE + 12800, 0, 0, 12799, 0, 0));

    for (int ph = 0; ph < 11; ph++) begin
      drain();
      plan_phase(ph, span);
      load_frustum($urandom_range(1));
      steady = (ph == 5);
      repeat (50) send_test(rand_test(span));
    end
    steady = 1'b0;

    drain();
    repeat (8) @(posedge clk);
    $display("Checked %0d test transactions (%0d visible, %0d culled) over %0d plane settings.",
             tests_checked, tests_visible, tests_checked - tests_visible, settings_used);
    if (fail_count == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
